// File: hdl/fcs_pkg.sv
// fcs_pkg: shared types and constants of the fuel cell supervisor
// beat structs, register map, configuration and controller/datapath interface
// no dependencies
package fcs_pkg;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	localparam logic [6:0]  FULL_DUTY  = 7'd100;
	localparam logic [6:0]  RAMP_STEP  = 7'd4;
	localparam logic [7:0]  W_ELEC     = 8'd77;
	localparam logic [7:0]  W_ELEC_OLD = 8'd179;
	localparam logic [7:0]  W_TEMP     = 8'd26;
	localparam logic [7:0]  W_TEMP_OLD = 8'd230;
	localparam logic [23:0] AVG_ROUND  = 24'd128;
	localparam logic [15:0] SIGN_FLIP  = 16'h8000;
	localparam logic [15:0] CAP_AVG_RST = 16'd6400;
	// ceil(2^32 / 100), exact for products below 2^30
	localparam logic [25:0] RECIP_100  = 26'd42949673;

	typedef enum logic [2:0] {
		REG_CAP_LOW    = 3'd0,
		REG_CAP_HIGH   = 3'd1,
		REG_MAX_TEMP   = 3'd2,
		REG_MAX_POWER  = 3'd3,
		REG_CELL_PER   = 3'd4,
		REG_BLOWER_PER = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		CH_CAP  = 2'd0,
		CH_CV   = 2'd1,
		CH_CI   = 2'd2,
		CH_TEMP = 2'd3
	} avg_ch_t;

	typedef struct packed {
		logic [15:0]        cap_voltage_sample;
		logic [15:0]        cell_voltage_sample;
		logic [15:0]        cell_current_sample;
		logic signed [15:0] temperature_sample;
		logic               manual_override;
	} in_beat_t;

	typedef struct packed {
		logic [6:0]  cell_duty;
		logic [16:0] cell_compare;
		logic [16:0] blower_compare;
		logic        stack_enable;
		logic        lockout;
		logic        charge_request;
		logic        soft_starting;
	} out_beat_t;

	typedef struct packed {
		logic [15:0]        cap_low_level;
		logic [15:0]        cap_high_level;
		logic signed [15:0] temp_limit;
		logic [31:0]        power_limit;
		logic [15:0]        cell_period;
		logic [15:0]        blower_period;
	} cfg_t;

	typedef struct packed {
		logic    load_in;
		logic    avg_en;
		avg_ch_t avg_sel;
		logic    pwr_en;
		logic    dec_en;
		logic    mul_en;
		logic    out_en;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

// File: hdl/fuel_cell_supervisor_core.sv
// one beat at a time: a new input beat is taken only in idle, after the sequencer
// steps one shared averaging unit over four channels, then the power, decision,
// compare multiply and reciprocal divide steps (the last stalls on a full output)
// the result register frees the input side while a result waits
// reset (arst_n low) loads register defaults and the averager/ramp state at once
// fuel_cell_supervisor_core: top level; uses fcs_pkg, fcs_regs, fcs_ctrl, fcs_dp
module fuel_cell_supervisor_core import fcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_beat_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_beat_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t    cfg;
	dp_cmd_t cmd;
	dp_sts_t sts;

	fcs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fcs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg       (cfg),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: hdl/fcs_regs.sv
// fcs_regs: configuration register file behind the apb-style port
// depends on fcs_pkg
module fcs_regs import fcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cap_low_level  <= 16'd5120;
			cfg_q.cap_high_level <= 16'd6400;
			cfg_q.temp_limit     <= 16'sd20480;
			cfg_q.power_limit    <= 32'hFFFF_FFFF;
			cfg_q.cell_period    <= 16'd999;
			cfg_q.blower_period  <= 16'd999;
		end else if (wr) begin
			unique case (idx)
				REG_CAP_LOW:    cfg_q.cap_low_level  <= pwdata[15:0];
				REG_CAP_HIGH:   cfg_q.cap_high_level <= pwdata[15:0];
				REG_MAX_TEMP:   cfg_q.temp_limit     <= pwdata[15:0];
				REG_MAX_POWER:  cfg_q.power_limit    <= pwdata;
				REG_CELL_PER:   cfg_q.cell_period    <= pwdata[15:0];
				REG_BLOWER_PER: cfg_q.blower_period  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CAP_LOW:    prdata = {16'd0, cfg_q.cap_low_level};
			REG_CAP_HIGH:   prdata = {16'd0, cfg_q.cap_high_level};
			REG_MAX_TEMP:   prdata = {16'd0, cfg_q.temp_limit};
			REG_MAX_POWER:  prdata = cfg_q.power_limit;
			REG_CELL_PER:   prdata = {16'd0, cfg_q.cell_period};
			REG_BLOWER_PER: prdata = {16'd0, cfg_q.blower_period};
			default:        prdata = '0;
		endcase
	end

endmodule

// File: hdl/fcs_ctrl.sv
// fcs_ctrl: sequencing state machine, one beat at a time through the datapath
// depends on fcs_pkg
module fcs_ctrl import fcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_AVG_CAP = 9'b000000010,
		S_AVG_CV  = 9'b000000100,
		S_AVG_CI  = 9'b000001000,
		S_AVG_TMP = 9'b000010000,
		S_PWR     = 9'b000100000,
		S_DEC     = 9'b001000000,
		S_MUL     = 9'b010000000,
		S_DIV     = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.avg_sel = CH_CAP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_AVG_CAP;
				end
			end
			S_AVG_CAP: begin
				cmd.avg_en  = 1'b1;
				cmd.avg_sel = CH_CAP;
				state_d     = S_AVG_CV;
			end
			S_AVG_CV: begin
				cmd.avg_en  = 1'b1;
				cmd.avg_sel = CH_CV;
				state_d     = S_AVG_CI;
			end
			S_AVG_CI: begin
				cmd.avg_en  = 1'b1;
				cmd.avg_sel = CH_CI;
				state_d     = S_AVG_TMP;
			end
			S_AVG_TMP: begin
				cmd.avg_en  = 1'b1;
				cmd.avg_sel = CH_TEMP;
				state_d     = S_PWR;
			end
			S_PWR: begin
				cmd.pwr_en = 1'b1;
				state_d    = S_DEC;
			end
			S_DEC: begin
				cmd.dec_en = 1'b1;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_DIV;
			end
			S_DIV: begin
				if (sts.out_free) begin
					cmd.out_en = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: hdl/fcs_dp.sv
// fcs_dp: averaging, power, thresholds, duty ramp and pwm compare datapath
// depends on fcs_pkg; driven by fcs_ctrl commands
module fcs_dp import fcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	input  cfg_t      cfg,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	in_beat_t    in_q;
	logic [15:0] cap_avg_q, cv_avg_q, ci_avg_q, temp_avg_q;
	logic [31:0] power_q;
	logic        charge_q, was_active_q, ramp_active_q, blower_q;
	logic [6:0]  ramp_duty_q, applied_q;
	logic        lock_q, active_q;
	logic [23:0] prod_q;
	logic        out_valid_q;
	out_beat_t   out_q;

	logic [15:0] smp, old;
	logic [7:0]  wa, wb;
	logic [23:0] wsum;
	logic [15:0] avg_new;

	logic        lock_c, flag_c, act_c, ramp_act_c, blower_c;
	logic [6:0]  ramp_c, applied_c;
	logic [49:0] quot_full;
	logic [16:0] cell_cmp;

	assign sts.out_free = ~out_valid_q | out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

	// temperature average is held offset-binary
	always_comb begin
		case (cmd.avg_sel)
			CH_CAP: begin
				smp = in_q.cap_voltage_sample;
				old = cap_avg_q;
			end
			CH_CV: begin
				smp = in_q.cell_voltage_sample;
				old = cv_avg_q;
			end
			CH_CI: begin
				smp = in_q.cell_current_sample;
				old = ci_avg_q;
			end
			default: begin
				smp = in_q.temperature_sample ^ SIGN_FLIP;
				old = temp_avg_q;
			end
		endcase
		wa = (cmd.avg_sel == CH_TEMP) ? W_TEMP : W_ELEC;
		wb = (cmd.avg_sel == CH_TEMP) ? W_TEMP_OLD : W_ELEC_OLD;
		wsum = 24'(smp) * 24'(wa) + 24'(old) * 24'(wb) + AVG_ROUND;
		avg_new = wsum[23:8];
	end

	always_comb begin
		lock_c = ($signed(temp_avg_q ^ SIGN_FLIP) > $signed(cfg.temp_limit)) ||
			(power_q > cfg.power_limit);
		flag_c = charge_q;
		if (cap_avg_q < cfg.cap_low_level) begin
			flag_c = 1'b1;
		end else if (cap_avg_q > cfg.cap_high_level) begin
			flag_c = 1'b0;
		end
		act_c      = (flag_c | in_q.manual_override) & ~lock_c;
		ramp_act_c = ramp_active_q;
		ramp_c     = ramp_duty_q;
		applied_c  = applied_q;
		blower_c   = blower_q;
		if (act_c && !was_active_q) begin
			ramp_act_c = 1'b1;
			ramp_c     = FULL_DUTY;
			blower_c   = 1'b1;
		end
		if (act_c) begin
			if (ramp_act_c) begin
				if (ramp_c != 7'd0) begin
					ramp_c    = (ramp_c > RAMP_STEP) ? ramp_c - RAMP_STEP : 7'd0;
					applied_c = ramp_c;
				end else begin
					ramp_act_c = 1'b0;
				end
			end else begin
				applied_c = 7'd0;
			end
		end else begin
			applied_c  = FULL_DUTY;
			blower_c   = 1'b0;
			ramp_act_c = 1'b0;
		end
	end

	// divide by 100 through the reciprocal
	assign quot_full = 50'(prod_q) * 50'(RECIP_100);
	assign cell_cmp  = quot_full[48:32];

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= in_data;
		end
		if (cmd.pwr_en) begin
			power_q <= 32'(cv_avg_q) * 32'(ci_avg_q);
		end
		if (cmd.mul_en) begin
			prod_q <= 24'(applied_q) * 24'({1'b0, cfg.cell_period} + 17'd1);
		end
		if (cmd.out_en) begin
			out_q.cell_duty      <= applied_q;
			out_q.cell_compare   <= cell_cmp;
			out_q.blower_compare <= blower_q ? {1'b0, cfg.blower_period} + 17'd1 : 17'd0;
			out_q.stack_enable   <= active_q;
			out_q.lockout        <= lock_q;
			out_q.charge_request <= charge_q;
			out_q.soft_starting  <= ramp_active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_avg_q     <= CAP_AVG_RST;
			cv_avg_q      <= '0;
			ci_avg_q      <= '0;
			temp_avg_q    <= SIGN_FLIP;
			charge_q      <= 1'b0;
			was_active_q  <= 1'b0;
			ramp_active_q <= 1'b0;
			ramp_duty_q   <= FULL_DUTY;
			applied_q     <= FULL_DUTY;
			blower_q      <= 1'b0;
			lock_q        <= 1'b0;
			active_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.avg_en) begin
				case (cmd.avg_sel)
					CH_CAP:  cap_avg_q  <= avg_new;
					CH_CV:   cv_avg_q   <= avg_new;
					CH_CI:   ci_avg_q   <= avg_new;
					default: temp_avg_q <= avg_new;
				endcase
			end
			if (cmd.dec_en) begin
				charge_q      <= flag_c;
				was_active_q  <= act_c;
				ramp_active_q <= ramp_act_c;
				ramp_duty_q   <= ramp_c;
				applied_q     <= applied_c;
				blower_q      <= blower_c;
				lock_q        <= lock_c;
				active_q      <= act_c;
			end
			if (cmd.out_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
